// ===== design/rts_pkg.sv =====
// Shared types and codes for the real-time task scheduler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package rts_pkg;

  localparam logic       ACT_RELEASE  = 1'b0;
  localparam logic       ACT_TICK     = 1'b1;

  localparam logic [1:0] KIND_IDLE    = 2'd0;
  localparam logic [1:0] KIND_RAN     = 2'd1;
  localparam logic [1:0] KIND_ACCEPT  = 2'd2;
  localparam logic [1:0] KIND_REJECT  = 2'd3;

  localparam logic [1:0] POL_EDF      = 2'd0;
  localparam logic [1:0] POL_SRT      = 2'd1;
  localparam logic [1:0] POL_LLF      = 2'd2;

  localparam logic       REG_POLICY   = 1'b0;
  localparam logic       REG_PREEMPT  = 1'b1;

  typedef struct packed {
    logic        action;
    logic [3:0]  task_id;
    logic [15:0] exec_time;
    logic [15:0] deadline;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  run_id;
    logic        done_res;
    logic [15:0] start_time;
    logic [15:0] end_time;
    logic [15:0] wait_time;
    logic        missed;
  } out_item_t;

  typedef struct packed {
    logic [1:0] policy;
    logic       preemptive;
  } cfg_t;

endpackage
`default_nettype wire

// ===== design/rts_front.sv =====
// Front end: two-entry command queue that takes release and tick items.
// Depends on rts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rts_front (
  input  wire               clk,
  input  wire               rst,
  input  wire               push,
  input  rts_pkg::in_item_t item,
  output logic              full,
  output logic              cmd_valid,
  output logic              cmd_tick,
  output rts_pkg::in_item_t cmd,
  input  wire               cmd_pop
);
  import rts_pkg::*;

  in_item_t   q [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rp];
  assign cmd_tick  = (q[rp].action == ACT_TICK);
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wp] <= item;
    end
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wp <= ~wp;
      end
      if (do_pop) begin
        rp <= ~rp;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule
`default_nettype wire

// ===== design/rts_back.sv =====
// Back end: slot store, selection scan and execution of one tick or release.
// Depends on rts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rts_back #(
  parameter int MAX_TASKS = 16,
  parameter int TIME_BITS = 16
) (
  input  wire                clk,
  input  wire                rst,
  input  rts_pkg::cfg_t      cfg,
  input  wire                cmd_valid,
  input  wire                cmd_tick,
  input  rts_pkg::in_item_t  cmd,
  output logic               cmd_pop,
  input  wire                res_ready,
  output logic               res_valid,
  output rts_pkg::out_item_t res
);
  import rts_pkg::*;

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int WB = (TIME_BITS > 16) ? TIME_BITS : 16;
  localparam int KW = WB + 2;
  localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_LOAD  = 3'd3;
  localparam logic [2:0] ST_EXEC  = 3'd4;

  typedef struct packed {
    logic [3:0]           id;
    logic [TIME_BITS-1:0] rel;
    logic [15:0]          exec;
    logic [15:0]          rem;
    logic [15:0]          dl;
    logic [TIME_BITS-1:0] start;
  } entry_t;

  entry_t               mem [MAX_TASKS];
  entry_t               rd;
  logic [IW-1:0]        rd_idx;
  logic                 rd_pend;
  logic [IW-1:0]        rd_addr;
  logic                 we;
  logic [IW-1:0]        wa;
  entry_t               wd;

  logic [MAX_TASKS-1:0] valid;
  logic [MAX_TASKS-1:0] started;
  logic [TIME_BITS-1:0] now;
  logic [IW-1:0]        run_slot;
  logic                 busy;

  logic [2:0]           state;
  logic [IW-1:0]        idx;
  logic                 found;
  logic [IW-1:0]        best;
  entry_t               best_e;
  logic signed [KW-1:0] bkey;

  logic [IW-1:0]        free_slot;
  logic                 free_found;
  logic signed [KW-1:0] key;
  logic                 take;
  logic [TIME_BITS-1:0] now_inc;
  logic signed [KW-1:0] now_x;
  logic signed [KW-1:0] nxt_x;
  logic signed [KW-1:0] wait_x;
  logic [15:0]          wait_c;
  logic                 fin;
  logic [TIME_BITS-1:0] start_v;
  logic [KW-1:0]        start_x;
  out_item_t            res_next;
  logic                 res_valid_next;

  // lowest free slot
  always_comb begin
    free_slot  = '0;
    free_found = 1'b0;
    for (int i = MAX_TASKS - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_slot  = IW'(i);
        free_found = 1'b1;
      end
    end
  end

  assign now_inc = (now == TMAX) ? now : now + 1'b1;
  assign now_x   = signed'(KW'(now));
  assign nxt_x   = signed'(KW'(now_inc));

  always_comb begin
    unique case (cfg.policy)
      POL_SRT: key = signed'(KW'(rd.rem));
      POL_LLF: key = signed'(KW'(rd.dl)) - now_x - signed'(KW'(rd.rem));
      default: key = signed'(KW'(rd.dl));
    endcase
  end

  assign take = rd_pend && valid[rd_idx] &&
                (!found || key < bkey || (key == bkey && rd.id < best_e.id));

  assign fin     = (best_e.rem <= 16'd1);
  assign start_v = started[best] ? best_e.start : now;
  assign start_x = KW'(start_v);
  assign wait_x  = nxt_x - signed'(KW'(best_e.rel)) - signed'(KW'(best_e.exec));
  always_comb begin
    if (wait_x < 0) begin
      wait_c = 16'd0;
    end else if (wait_x > signed'(KW'(16'hFFFF))) begin
      wait_c = 16'hFFFF;
    end else begin
      wait_c = wait_x[15:0];
    end
  end

  assign rd_addr = (state == ST_IDLE) ? run_slot : idx;

  // store write port
  always_comb begin
    we = 1'b0;
    wa = best;
    wd = best_e;
    if (state == ST_IDLE && cmd_valid && res_ready && !cmd_tick && free_found) begin
      we      = 1'b1;
      wa      = free_slot;
      wd.id   = cmd.task_id;
      wd.rel  = now;
      wd.exec = cmd.exec_time;
      wd.rem  = cmd.exec_time;
      wd.dl   = cmd.deadline;
      wd.start = '0;
    end else if (state == ST_EXEC) begin
      we       = 1'b1;
      wd.start = start_v;
      wd.rem   = fin ? 16'd0 : best_e.rem - 16'd1;
    end
  end

  assign cmd_pop = (state == ST_IDLE) && cmd_valid && res_ready;

  // result of the item that finishes this cycle
  always_comb begin
    res_next       = '0;
    res_valid_next = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (cmd_pop && !cmd_tick) begin
          res_next.run_id = cmd.task_id;
          res_next.kind   = free_found ? KIND_ACCEPT : KIND_REJECT;
          res_valid_next  = 1'b1;
        end
      end
      ST_DRAIN: begin
        // nothing ready: idle tick
        res_valid_next = !(found || take);
      end
      ST_EXEC: begin
        res_next.kind   = KIND_RAN;
        res_next.run_id = best_e.id;
        res_valid_next  = 1'b1;
        if (fin) begin
          res_next.done_res   = 1'b1;
          res_next.start_time = start_x[15:0];
          res_next.end_time   = nxt_x[15:0];
          res_next.wait_time  = wait_c;
          res_next.missed     = (nxt_x > signed'(KW'(best_e.dl)));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd     <= mem[rd_addr];
    rd_idx <= rd_addr;
    res    <= res_next;
    if (take) begin
      best_e <= rd;
      bkey   <= key;
      best   <= rd_idx;
    end
    unique case (state)
      ST_LOAD: begin
        best_e <= rd;
        best   <= run_slot;
      end
      default: ;
    endcase

    if (rst) begin
      state     <= ST_IDLE;
      valid     <= '0;
      started   <= '0;
      now       <= '0;
      run_slot  <= '0;
      busy      <= 1'b0;
      idx       <= '0;
      found     <= 1'b0;
      rd_pend   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= res_valid_next;
      rd_pend   <= (state == ST_SCAN);
      unique case (state)
        ST_IDLE: begin
          if (cmd_pop) begin
            if (!cmd_tick) begin
              if (free_found) begin
                valid[free_slot]   <= 1'b1;
                started[free_slot] <= 1'b0;
              end
            end else if (!cfg.preemptive && busy && valid[run_slot]) begin
              state <= ST_LOAD;
            end else begin
              idx   <= '0;
              found <= 1'b0;
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (take) begin
            found <= 1'b1;
          end
          if (idx == IW'(MAX_TASKS - 1)) begin
            state <= ST_DRAIN;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (found || take) begin
            state <= ST_EXEC;
          end else begin
            // nothing ready: idle tick
            now   <= now_inc;
            busy  <= 1'b0;
            state <= ST_IDLE;
          end
        end
        ST_LOAD: begin
          state <= ST_EXEC;
        end
        ST_EXEC: begin
          now   <= now_inc;
          state <= ST_IDLE;
          if (fin) begin
            valid[best]   <= 1'b0;
            started[best] <= 1'b0;
            busy          <= 1'b0;
            run_slot      <= '0;
          end else begin
            started[best] <= 1'b1;
            busy          <= 1'b1;
            run_slot      <= best;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/realtime_task_scheduler.sv =====
// Real-time task scheduler: a release is handled by the back end in its idle state; a tick
// scans the slot store (one slot read per cycle through the store's single read port) and
// then runs the chosen task, or gives an idle tick when the scan finds no ready task; a
// non-preemptive task that keeps running is loaded without a scan. Items queue in a
// two-entry front queue; each result passes through the back end's result register into
// the output register and waits there until popped, and the back end starts the next
// item only once that register is free and no result is on its way to it.
// Depends on rts_pkg, rts_front and rts_back.
`timescale 1ns / 1ps
`default_nettype none
module realtime_task_scheduler #(
  parameter int MAX_TASKS = 16,
  parameter int TIME_BITS = 16
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  input  rts_pkg::in_item_t  item,
  output logic               full,
  output logic               empty,
  input  wire                pop,
  output rts_pkg::out_item_t result,
  input  wire                wr_en,
  input  wire                wr_index,
  input  wire [1:0]          wr_data
);
  import rts_pkg::*;

  cfg_t      cfg;
  logic      cmd_valid;
  logic      cmd_tick;
  in_item_t  cmd;
  logic      cmd_pop;
  logic      res_valid;
  out_item_t res;
  logic      out_valid;

  always_ff @(posedge clk) begin
    if (res_valid) begin
      result <= res;
    end
    if (rst) begin
      cfg.policy     <= POL_EDF;
      cfg.preemptive <= 1'b1;
      out_valid      <= 1'b0;
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          REG_POLICY:  cfg.policy     <= wr_data;
          REG_PREEMPT: cfg.preemptive <= wr_data[0];
          default: ;
        endcase
      end
      // hold the result until its transfer
      if (res_valid) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign empty = !out_valid;

  rts_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .cmd_valid (cmd_valid),
    .cmd_tick  (cmd_tick),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  rts_back #(
    .MAX_TASKS (MAX_TASKS),
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd_tick  (cmd_tick),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_ready (!out_valid && !res_valid),
    .res_valid (res_valid),
    .res       (res)
  );

endmodule
`default_nettype wire

// ===== bench/realtime_task_scheduler_tb.sv =====
// Self-checking bench for the real-time task scheduler: releases and ticks are
// pushed in, each popped result is compared against a behavioral scheduler model.
// Depends on rts_pkg and the realtime_task_scheduler RTL.
`timescale 1ns / 1ps
`default_nettype none
module realtime_task_scheduler_tb;
  import rts_pkg::*;

  localparam int NSLOT = 16;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  in_item_t  item = '0;
  logic      full;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t result;
  logic      wr_en = 1'b0;
  logic      wr_index = 1'b0;
  logic [1:0] wr_data = 2'd0;

  realtime_task_scheduler u_dut (
    .clk(clk), .rst(rst), .push(push), .item(item), .full(full), .empty(empty),
    .pop(pop), .result(result), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  always #5 clk = ~clk;

  // scheduler model state
  logic [1:0]  m_policy = POL_EDF;
  logic        m_preempt = 1'b1;
  logic        m_valid [NSLOT];
  logic [3:0]  m_id [NSLOT];
  logic [15:0] m_release [NSLOT];
  logic [15:0] m_exec [NSLOT];
  logic [15:0] m_remain [NSLOT];
  logic [15:0] m_deadline [NSLOT];
  logic [15:0] m_start [NSLOT];
  logic        m_started [NSLOT];
  logic [15:0] m_now = '0;
  int          m_run_slot = 0;
  logic        m_run_busy = 1'b0;

  out_item_t   sched_expect_q[$];
  int          errors = 0;
  int          results_seen = 0;
  int          completions = 0;
  int          misses_seen = 0;
  int          rejects_seen = 0;
  logic        pop_idle_en = 1'b1;
  logic        push_idle_en = 1'b1;

  initial begin
    for (int s = 0; s < NSLOT; s++) begin
      m_valid[s] = 1'b0;
      m_started[s] = 1'b0;
    end
  end

  function automatic longint sched_key(int s);
    if (m_policy == POL_SRT) return longint'(m_remain[s]);
    if (m_policy == POL_LLF)
      return longint'(m_deadline[s]) - longint'(m_now) - longint'(m_remain[s]);
    return longint'(m_deadline[s]);
  endfunction

  function automatic int pick_slot();
    int best;
    longint bkey;
    longint k;
    best = NSLOT;
    bkey = 0;
    for (int s = 0; s < NSLOT; s++) begin
      if (m_valid[s]) begin
        k = sched_key(s);
        if (best == NSLOT || k < bkey || (k == bkey && m_id[s] < m_id[best])) begin
          best = s;
          bkey = k;
        end
      end
    end
    return best;
  endfunction

  function automatic out_item_t schedule_step(in_item_t it);
    out_item_t r;
    int s;
    longint w;
    r = '0;
    if (it.action == ACT_RELEASE) begin
      r.run_id = it.task_id;
      s = 0;
      while (s < NSLOT && m_valid[s]) s++;
      if (s >= NSLOT) begin
        r.kind = KIND_REJECT;
        return r;
      end
      m_valid[s] = 1'b1;
      m_id[s] = it.task_id;
      m_release[s] = m_now;
      m_exec[s] = it.exec_time;
      m_remain[s] = it.exec_time;
      m_deadline[s] = it.deadline;
      m_start[s] = '0;
      m_started[s] = 1'b0;
      r.kind = KIND_ACCEPT;
      return r;
    end
    if (m_preempt || !m_run_busy || !m_valid[m_run_slot]) s = pick_slot();
    else s = m_run_slot;
    if (s >= NSLOT) begin
      m_run_busy = 1'b0;
      if (m_now != 16'hFFFF) m_now++;
      r.kind = KIND_IDLE;
      return r;
    end
    if (!m_started[s]) begin
      m_started[s] = 1'b1;
      m_start[s] = m_now;
    end
    if (m_now != 16'hFFFF) m_now++;
    r.kind = KIND_RAN;
    r.run_id = m_id[s];
    if (m_remain[s] <= 16'd1) begin
      w = longint'(m_now) - longint'(m_release[s]) - longint'(m_exec[s]);
      if (w < 0) w = 0;
      if (w > 65535) w = 65535;
      r.done_res = 1'b1;
      r.start_time = m_start[s];
      r.end_time = m_now;
      r.wait_time = w[15:0];
      r.missed = (m_now > m_deadline[s]);
      m_remain[s] = '0;
      m_valid[s] = 1'b0;
      m_started[s] = 1'b0;
      m_run_busy = 1'b0;
      m_run_slot = 0;
    end else begin
      m_remain[s]--;
      m_run_busy = 1'b1;
      m_run_slot = s;
    end
    return r;
  endfunction

  // hold push low for a random burst, sometimes
  task automatic push_gap();
    int n;
    if (push_idle_en && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 14);
      push <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_item(in_item_t it);
    out_item_t exp_r;
    push_gap();
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    exp_r = schedule_step(it);
    sched_expect_q.insert(sched_expect_q.size(), exp_r);
  endtask

  task automatic send_release(logic [3:0] id, logic [15:0] ex, logic [15:0] dl);
    in_item_t it;
    it.action = ACT_RELEASE;
    it.task_id = id;
    it.exec_time = ex;
    it.deadline = dl;
    send_item(it);
  endtask

  task automatic send_tick();
    in_item_t it;
    it.action = ACT_TICK;
    it.task_id = 4'($urandom);
    it.exec_time = 16'($urandom);
    it.deadline = 16'($urandom);
    send_item(it);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sched_expect_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [1:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    if (idx == REG_POLICY) m_policy = val;
    else m_preempt = val[0];
  endtask

  task automatic set_mode(logic [1:0] pol, logic pre);
    drain();
    write_reg(REG_POLICY, pol);
    write_reg(REG_PREEMPT, pre);
    wr_en <= 1'b0;
  endtask

  // result side: random stalls, compare each transfer with the oldest expectation
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      results_seen++;
      if (sched_expect_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", result);
      end else begin
        if (result !== sched_expect_q[0]) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected %p got %p", sched_expect_q[0], result);
        end
        if (sched_expect_q[0].done_res) completions++;
        if (sched_expect_q[0].missed) misses_seen++;
        if (sched_expect_q[0].kind == KIND_REJECT) rejects_seen++;
        void'(sched_expect_q.pop_front());
      end
    end
  end

  int pop_hold = 0;
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (pop_hold > 0) begin
      pop_hold <= pop_hold - 1;
      pop <= 1'b0;
    end else if (pop_idle_en && $urandom_range(0, 7) == 0) begin
      pop_hold <= $urandom_range(0, 13);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic test_directed();
    send_tick();                             // idle tick on empty store
    send_release(4'hF, 16'hFFFF, 16'hFFFF);
    send_release(4'h0, 16'd0, 16'd0);        // zero exec time
    send_release(4'h3, 16'd2, 16'd1);
    send_release(4'h3, 16'd2, 16'd1);        // equal id and key
    send_release(4'h1, 16'd1, 16'h0000);
    repeat (8) send_tick();
    for (int i = 0; i < 17; i++) send_release(4'(i), 16'd1, 16'(i));  // overflow store
    drain();
  endtask

  task automatic test_policy(logic [1:0] pol, logic pre, int n_items);
    set_mode(pol, pre);
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 99) < 40) begin
        if ($urandom_range(0, 3) == 0)
          send_release(4'($urandom), 16'($urandom), 16'($urandom));
        else
          send_release(4'($urandom), 16'($urandom_range(0, 6)),
                       m_now + 16'($urandom_range(0, 40)));
      end else begin
        send_tick();
      end
    end
  endtask

  // zero- to two-unit tasks under both selection modes
  task automatic test_short_tasks();
    set_mode(POL_EDF, 1'b1);
    send_release(4'h7, 16'd0, 16'd5);
    send_release(4'h2, 16'd1, 16'd0);
    repeat (3) send_tick();
    set_mode(POL_LLF, 1'b0);
    for (int i = 0; i < 6; i++) send_release(4'(5 - i), 16'(i % 3), m_now + 16'(i));
    repeat (12) send_tick();
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_policy(POL_EDF, 1'b1, 300);
    test_policy(POL_SRT, 1'b0, 300);
    test_policy(POL_LLF, 1'b1, 300);
    test_policy(2'd3, 1'b0, 250);            // unused policy code acts as deadline
    test_policy(POL_SRT, 1'b1, 250);
    pop_idle_en = 1'b0;
    push_idle_en = 1'b0;
    test_policy(POL_LLF, 1'b0, 300);
    test_short_tasks();
    drain();
    $display("covered %0d results, %0d completions, %0d deadline misses, %0d rejects",
             results_seen, completions, misses_seen, rejects_seen);
    if (errors == 0 && sched_expect_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire
